// ===== hdl/cpu_register_alu_execute_top_assert.svh =====
// assertion macros for the cpu register alu execute block
// depends on nothing; included by the top level
`ifndef CPU_REGISTER_ALU_EXECUTE_TOP_ASSERT_SVH
`define CPU_REGISTER_ALU_EXECUTE_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, skipped during reset
`define CRAE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication, skipped during reset
`define CRAE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CRAE_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define CRAE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== hdl/crae_pkg.sv =====
// opcode classes and decoder for the cpu register alu execute block
// depends on nothing
package crae_pkg;

  // status flag bit positions
  localparam logic [2:0] FLAG_N = 3'd7;
  localparam logic [2:0] FLAG_V = 3'd6;
  localparam logic [2:0] FLAG_D = 3'd3;
  localparam logic [2:0] FLAG_I = 3'd2;
  localparam logic [2:0] FLAG_Z = 3'd1;
  localparam logic [2:0] FLAG_C = 3'd0;

  typedef enum logic [5:0] {
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_STX, OP_STY,
    OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_TSX, OP_TXS,
    OP_ADC, OP_SBC, OP_AND, OP_EOR, OP_ORA,
    OP_CMP, OP_CPX, OP_CPY, OP_BIT,
    OP_INX, OP_INY, OP_DEX, OP_DEY,
    OP_ASL, OP_LSR, OP_ROL, OP_ROR,
    OP_CLC, OP_CLD, OP_CLI, OP_CLV, OP_SEC, OP_SED, OP_SEI,
    OP_NOP, OP_BRK, OP_ILL
  } op_class_t;

  // map an opcode byte onto its operation, every addressing mode alike but for memory read-modify-write
  function automatic op_class_t decode(input logic [7:0] op);
    op_class_t cls;
    unique case (op)
      8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: cls = OP_LDA;
      8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE:                      cls = OP_LDX;
      8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC:                      cls = OP_LDY;
      8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91:        cls = OP_STA;
      8'h86, 8'h96, 8'h8E:                                    cls = OP_STX;
      8'h84, 8'h94, 8'h8C:                                    cls = OP_STY;
      8'hAA: cls = OP_TAX;
      8'hA8: cls = OP_TAY;
      8'h8A: cls = OP_TXA;
      8'h98: cls = OP_TYA;
      8'hBA: cls = OP_TSX;
      8'h9A: cls = OP_TXS;
      8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: cls = OP_ADC;
      8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: cls = OP_SBC;
      8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: cls = OP_AND;
      8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: cls = OP_EOR;
      8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: cls = OP_ORA;
      8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: cls = OP_CMP;
      8'hE0, 8'hE4, 8'hEC: cls = OP_CPX;
      8'hC0, 8'hC4, 8'hCC: cls = OP_CPY;
      8'h24, 8'h2C:        cls = OP_BIT;
      8'hE8: cls = OP_INX;
      8'hC8: cls = OP_INY;
      8'hCA: cls = OP_DEX;
      8'h88: cls = OP_DEY;
      8'h0A: cls = OP_ASL;
      8'h4A: cls = OP_LSR;
      8'h2A: cls = OP_ROL;
      8'h6A: cls = OP_ROR;
      8'h18: cls = OP_CLC;
      8'hD8: cls = OP_CLD;
      8'h58: cls = OP_CLI;
      8'hB8: cls = OP_CLV;
      8'h38: cls = OP_SEC;
      8'hF8: cls = OP_SED;
      8'h78: cls = OP_SEI;
      // stack, jumps, branches, memory read-modify-write and nop do nothing here
      8'h48, 8'h68, 8'h08, 8'h28,
      8'hE6, 8'hF6, 8'hEE, 8'hFE,
      8'hC6, 8'hD6, 8'hCE, 8'hDE,
      8'h06, 8'h16, 8'h0E, 8'h1E,
      8'h46, 8'h56, 8'h4E, 8'h5E,
      8'h26, 8'h36, 8'h2E, 8'h3E,
      8'h66, 8'h76, 8'h6E, 8'h7E,
      8'h4C, 8'h6C, 8'h20, 8'h60,
      8'h90, 8'hB0, 8'hF0, 8'hD0,
      8'h30, 8'h10, 8'h50, 8'h70,
      8'hEA: cls = OP_NOP;
      8'h00: cls = OP_BRK;
      default: cls = OP_ILL;
    endcase
    return cls;
  endfunction

endpackage

// ===== hdl/cpu_register_alu_execute_top.sv =====
// cpu register alu execute block: 8-bit accumulator machine execute stage
// an accepted transaction passes the input reg, then the result reg, before result valid
// throughput: one instruction per cycle while out_stall is low; the combinational execute
// pass through the alu and flag logic sets the rate, and results leave in order
// reset: a, x, y, status and stack pointer clear to zero, both stages empty
// depends on crae_pkg and cpu_register_alu_execute_top_assert.svh
`include "cpu_register_alu_execute_top_assert.svh"

module cpu_register_alu_execute_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] op,
  input  logic [7:0] operand,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] acc_out,
  output logic [7:0] x_out,
  output logic [7:0] y_out,
  output logic [7:0] flags_out,
  output logic [7:0] sp_out,
  output logic       store_valid,
  output logic [7:0] store_data,
  output logic       halted,
  output logic       illegal
);

  // input register
  logic       s1_valid;
  logic [7:0] s1_op;
  logic [7:0] s1_operand;

  // architectural state
  logic [7:0] acc;
  logic [7:0] x_reg;
  logic [7:0] y_reg;
  logic [7:0] flags;
  logic [7:0] sp;

  // result register side fields
  logic       st_reg;
  logic [7:0] sdata_reg;
  logic       halt_reg;
  logic       bad_reg;

  // execute pass
  crae_pkg::op_class_t cls;
  logic [7:0] acc_next;
  logic [7:0] x_next;
  logic [7:0] y_next;
  logic [7:0] flags_next;
  logic [7:0] sp_next;
  logic       st_next;
  logic [7:0] sdata_next;
  logic       halt_next;
  logic       bad_next;
  logic [7:0] zn_val;
  logic       zn_en;
  logic [7:0] add_b;
  logic [8:0] sum;
  logic [7:0] cmp_reg;
  logic [7:0] cmp_diff;

  logic out_ready;
  logic s1_load;
  logic exec;

  // handshake control
  assign out_ready = !out_valid || !out_stall;
  assign exec      = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;
  assign s1_load   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (exec) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_op      <= op;
      s1_operand <= operand;
    end
  end

  // shared adder and comparator
  assign cls      = crae_pkg::decode(s1_op);
  assign add_b    = (cls == crae_pkg::OP_SBC) ? ~s1_operand : s1_operand;
  assign sum      = {1'b0, acc} + {1'b0, add_b} + {8'h00, flags[crae_pkg::FLAG_C]};
  assign cmp_reg  = (cls == crae_pkg::OP_CPX) ? x_reg :
                    (cls == crae_pkg::OP_CPY) ? y_reg : acc;
  assign cmp_diff = cmp_reg - s1_operand;

  // instruction execute
  always_comb begin
    acc_next   = acc;
    x_next     = x_reg;
    y_next     = y_reg;
    flags_next = flags;
    sp_next    = sp;
    st_next    = 1'b0;
    sdata_next = 8'h00;
    halt_next  = 1'b0;
    bad_next   = 1'b0;
    zn_val     = 8'h00;
    zn_en      = 1'b0;
    unique case (cls)
      crae_pkg::OP_LDA: begin acc_next = s1_operand; zn_val = s1_operand; zn_en = 1'b1; end
      crae_pkg::OP_LDX: begin x_next = s1_operand; zn_val = s1_operand; zn_en = 1'b1; end
      crae_pkg::OP_LDY: begin y_next = s1_operand; zn_val = s1_operand; zn_en = 1'b1; end
      crae_pkg::OP_STA: begin st_next = 1'b1; sdata_next = acc; end
      crae_pkg::OP_STX: begin st_next = 1'b1; sdata_next = x_reg; end
      crae_pkg::OP_STY: begin st_next = 1'b1; sdata_next = y_reg; end
      crae_pkg::OP_TAX: begin x_next = acc; zn_val = acc; zn_en = 1'b1; end
      crae_pkg::OP_TAY: begin y_next = acc; zn_val = acc; zn_en = 1'b1; end
      crae_pkg::OP_TXA: begin acc_next = x_reg; zn_val = x_reg; zn_en = 1'b1; end
      crae_pkg::OP_TYA: begin acc_next = y_reg; zn_val = y_reg; zn_en = 1'b1; end
      crae_pkg::OP_TSX: begin x_next = sp; zn_val = sp; zn_en = 1'b1; end
      crae_pkg::OP_TXS: begin sp_next = x_reg; end
      crae_pkg::OP_ADC, crae_pkg::OP_SBC: begin
        acc_next = sum[7:0];
        flags_next[crae_pkg::FLAG_C] = sum[8];
        flags_next[crae_pkg::FLAG_V] = (acc[7] ^ sum[7]) & (add_b[7] ^ sum[7]);
        zn_val = sum[7:0];
        zn_en  = 1'b1;
      end
      crae_pkg::OP_AND: begin
        acc_next = acc & s1_operand; zn_val = acc & s1_operand; zn_en = 1'b1;
      end
      crae_pkg::OP_EOR: begin
        acc_next = acc ^ s1_operand; zn_val = acc ^ s1_operand; zn_en = 1'b1;
      end
      crae_pkg::OP_ORA: begin
        acc_next = acc | s1_operand; zn_val = acc | s1_operand; zn_en = 1'b1;
      end
      crae_pkg::OP_CMP, crae_pkg::OP_CPX, crae_pkg::OP_CPY: begin
        zn_val = cmp_diff;
        zn_en  = 1'b1;
        flags_next[crae_pkg::FLAG_C] = (cmp_reg >= s1_operand);
      end
      crae_pkg::OP_BIT: begin
        flags_next[crae_pkg::FLAG_Z] = ((acc & s1_operand) == 8'h00);
        flags_next[crae_pkg::FLAG_N] = s1_operand[7];
        flags_next[crae_pkg::FLAG_V] = s1_operand[6];
      end
      crae_pkg::OP_INX: begin x_next = x_reg + 8'h01; zn_val = x_reg + 8'h01; zn_en = 1'b1; end
      crae_pkg::OP_INY: begin y_next = y_reg + 8'h01; zn_val = y_reg + 8'h01; zn_en = 1'b1; end
      crae_pkg::OP_DEX: begin x_next = x_reg - 8'h01; zn_val = x_reg - 8'h01; zn_en = 1'b1; end
      crae_pkg::OP_DEY: begin y_next = y_reg - 8'h01; zn_val = y_reg - 8'h01; zn_en = 1'b1; end
      crae_pkg::OP_ASL: begin
        acc_next = {acc[6:0], 1'b0}; zn_val = {acc[6:0], 1'b0}; zn_en = 1'b1;
        flags_next[crae_pkg::FLAG_C] = acc[7];
      end
      crae_pkg::OP_LSR: begin
        acc_next = {1'b0, acc[7:1]}; zn_val = {1'b0, acc[7:1]}; zn_en = 1'b1;
        flags_next[crae_pkg::FLAG_C] = acc[0];
      end
      crae_pkg::OP_ROL: begin
        acc_next = {acc[6:0], flags[crae_pkg::FLAG_C]};
        zn_val   = {acc[6:0], flags[crae_pkg::FLAG_C]};
        zn_en    = 1'b1;
        flags_next[crae_pkg::FLAG_C] = acc[7];
      end
      crae_pkg::OP_ROR: begin
        acc_next = {flags[crae_pkg::FLAG_C], acc[7:1]};
        zn_val   = {flags[crae_pkg::FLAG_C], acc[7:1]};
        zn_en    = 1'b1;
        flags_next[crae_pkg::FLAG_C] = acc[0];
      end
      crae_pkg::OP_CLC: flags_next[crae_pkg::FLAG_C] = 1'b0;
      crae_pkg::OP_CLD: flags_next[crae_pkg::FLAG_D] = 1'b0;
      crae_pkg::OP_CLI: flags_next[crae_pkg::FLAG_I] = 1'b0;
      crae_pkg::OP_CLV: flags_next[crae_pkg::FLAG_V] = 1'b0;
      crae_pkg::OP_SEC: flags_next[crae_pkg::FLAG_C] = 1'b1;
      crae_pkg::OP_SED: flags_next[crae_pkg::FLAG_D] = 1'b1;
      crae_pkg::OP_SEI: flags_next[crae_pkg::FLAG_I] = 1'b1;
      crae_pkg::OP_NOP: begin end
      crae_pkg::OP_BRK: halt_next = 1'b1;
      crae_pkg::OP_ILL: bad_next = 1'b1;
      default:          bad_next = 1'b1;
    endcase
    // zero and negative from the result byte
    if (zn_en) begin
      flags_next[crae_pkg::FLAG_Z] = (zn_val == 8'h00);
      flags_next[crae_pkg::FLAG_N] = zn_val[7];
    end
  end

  // state and result register, updated only when the result slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'h00;
      x_reg <= 8'h00;
      y_reg <= 8'h00;
      flags <= 8'h00;
      sp    <= 8'h00;
    end else if (exec) begin
      acc   <= acc_next;
      x_reg <= x_next;
      y_reg <= y_next;
      flags <= flags_next;
      sp    <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      st_reg    <= st_next;
      sdata_reg <= sdata_next;
      halt_reg  <= halt_next;
      bad_reg   <= bad_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // state holds while a result waits, so it doubles as the result payload
  assign acc_out     = acc;
  assign x_out       = x_reg;
  assign y_out       = y_reg;
  assign flags_out   = flags;
  assign sp_out      = sp;
  assign store_valid = st_reg;
  assign store_data  = sdata_reg;
  assign halted      = halt_reg;
  assign illegal     = bad_reg;

  // checks
  `CRAE_ASSERT_NEXT(a_halt_ill_keep_state, clk, rst,
    exec && (cls == crae_pkg::OP_BRK || cls == crae_pkg::OP_ILL),
    $stable(acc) && $stable(x_reg) && $stable(y_reg) && $stable(flags) && $stable(sp),
    "halt or illegal changed state")
  `CRAE_ASSERT_IMPLIES(a_store_exclusive, clk, rst, out_valid && store_valid,
    !halted && !illegal, "store flagged with halt or illegal")
  `CRAE_ASSERT_IMPLIES(a_unused_flags_zero, clk, rst, 1'b1,
    flags[5:4] == 2'b00, "unused status bits set")
  `CRAE_ASSERT_NEXT(a_stall_holds_input, clk, rst, s1_valid && out_valid && out_stall,
    s1_valid && $stable(s1_op) && $stable(s1_operand), "input register lost under stall")
  `CRAE_ASSERT_NEXT(a_state_frozen_when_idle, clk, rst, !exec,
    $stable(acc) && $stable(flags), "state changed without execute")

endmodule
